FILE: design/middle_insert_queue_defines.svh
// Assertion macros shared by the queue design.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef MIDDLE_INSERT_QUEUE_DEFINES_SVH
`define MIDDLE_INSERT_QUEUE_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define MIQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("middle_insert_queue: same-cycle check failed");

// Next-cycle implication, checked only while out of reset.
`define MIQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("middle_insert_queue: next-cycle check failed");

`endif

FILE: design/miq_pkg.sv
`timescale 1ns / 1ps

package miq_pkg;

  localparam int CAPACITY   = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int VAL_W      = 32;
  localparam int HALF_DEPTH = CAPACITY / 2 + 1;
  localparam int IDX_W      = $clog2(HALF_DEPTH);
  localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
  localparam int TOT_W      = $clog2(CAPACITY + 1);
  localparam int SUM_W      = CNT_W + 1;

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;

  typedef enum logic [1:0] {
    STAT_INSERTED,
    STAT_POPPED,
    STAT_FULL,
    STAT_EMPTY
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] popped_value;
    status_t                 status;
  } out_word_t;

  // Position offset entries past idx in a ring of HALF_DEPTH entries.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(idx) + SUM_W'(off);
    if (sum >= SUM_W'(HALF_DEPTH)) begin
      sum = sum - SUM_W'(HALF_DEPTH);
    end
    return IDX_W'(sum);
  endfunction

  // Size of the front half for a queue of t entries, ceil(t/2).
  function automatic logic [TOT_W-1:0] half_up(input logic [TOT_W-1:0] t);
    logic [TOT_W:0] sum;
    sum = {1'b0, t} + (TOT_W + 1)'(1);
    return TOT_W'(sum >> 1);
  endfunction

endpackage

FILE: design/miq_ram.sv
`timescale 1ns / 1ps

module miq_ram #(
  parameter int DEPTH  = 513,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/middle_insert_queue.sv
`timescale 1ns / 1ps
// Queue of signed words with push at the tail, pop at the head and insert
// at the middle. Each input word carries a mode and a value; each accepted
// word produces exactly one output word with the popped value and a status.
// Both channels use valid/stall: a word moves on a rising edge where valid
// is high and stall is low.
// The queue is held as two ring halves in two single-port-read memories.
// An operation runs as an accept step (ST_IDLE) and a finish step (ST_FIN):
// the accept step updates all pointers and counts, issues the head reads and
// does any single write; the finish step takes the read data, writes the
// element that moves from the back half to the front half, and loads the
// output register. No new word is taken until the previous one has finished.
// A finished word waits in the output register while the next input word is
// accepted; if the output is still stalled when that second word finishes,
// the sequencer holds in its finish step and input stall stays high.
// Reset clears pointers, counts and control state; memory contents are not
// cleared, since an entry is only ever read after it was written.

module middle_insert_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  miq_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output miq_pkg::out_word_t  out_word
);

  import miq_pkg::*;

  `include "middle_insert_queue_defines.svh"

  // Sequencer state and queue bookkeeping.
  state_t           st_r, st_nxt;
  logic [IDX_W-1:0] fh_r, fh_nxt;
  logic [CNT_W-1:0] fc_r, fc_nxt;
  logic [IDX_W-1:0] bh_r, bh_nxt;
  logic [CNT_W-1:0] bc_r, bc_nxt;
  logic [TOT_W-1:0] tot_r, tot_nxt;

  // Per-operation context carried into the finish step.
  status_t               stat_r, stat_nxt;
  logic                  pop_ok_r, pop_ok_nxt;
  logic                  mv_r, mv_nxt;
  logic                  mv_fwd_r, mv_fwd_nxt;
  logic [IDX_W-1:0]      mv_addr_r, mv_addr_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  logic      out_load;

  // Memory ports.
  logic                  f_we, f_re, b_we, b_re;
  logic [IDX_W-1:0]      f_wa, f_ra, b_wa, b_ra;
  logic [DATA_WIDTH-1:0] f_wd, f_rd, b_wd, b_rd;
  logic signed [DATA_WIDTH-1:0] f_rd_s;

  // Precomputed ring positions.
  logic [IDX_W-1:0] fh_inc, bh_inc, bh_dec, front_tail, back_tail, pop_tail;
  logic [CNT_W-1:0] fc_dec;
  logic [TOT_W-1:0] tot_dec, tot_inc;
  logic             accept;

  assign accept     = in_valid && (st_r == ST_IDLE);
  assign in_stall   = (st_r != ST_IDLE);
  assign fc_dec     = fc_r - CNT_W'(1);
  assign tot_dec    = tot_r - TOT_W'(1);
  assign tot_inc    = tot_r + TOT_W'(1);
  assign fh_inc     = ring_add(fh_r, CNT_W'(1));
  assign bh_inc     = ring_add(bh_r, CNT_W'(1));
  assign bh_dec     = (bh_r == '0) ? IDX_W'(HALF_DEPTH - 1) : bh_r - IDX_W'(1);
  assign front_tail = ring_add(fh_r, fc_r);
  assign back_tail  = ring_add(bh_r, bc_r);
  // Front tail after the head moved on and one entry left.
  assign pop_tail   = ring_add(fh_inc, fc_dec);
  assign f_rd_s     = f_rd;

  miq_ram #(
    .DEPTH (HALF_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_front_ram (
    .clk     (clk),
    .wr_en   (f_we),
    .wr_addr (f_wa),
    .wr_data (f_wd),
    .rd_en   (f_re),
    .rd_addr (f_ra),
    .rd_data (f_rd)
  );

  miq_ram #(
    .DEPTH (HALF_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_back_ram (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (b_wa),
    .wr_data (b_wd),
    .rd_en   (b_re),
    .rd_addr (b_ra),
    .rd_data (b_rd)
  );

  always_comb begin
    st_nxt      = st_r;
    fh_nxt      = fh_r;
    fc_nxt      = fc_r;
    bh_nxt      = bh_r;
    bc_nxt      = bc_r;
    tot_nxt     = tot_r;
    stat_nxt    = stat_r;
    pop_ok_nxt  = pop_ok_r;
    mv_nxt      = mv_r;
    mv_fwd_nxt  = mv_fwd_r;
    mv_addr_nxt = mv_addr_r;
    val_nxt     = val_r;
    out_load    = 1'b0;
    f_we        = 1'b0;
    f_wa        = front_tail;
    f_wd        = val_r;
    b_we        = 1'b0;
    b_wa        = back_tail;
    b_wd        = val_r;
    // Both head reads are issued on every accepted word.
    f_re        = accept;
    f_ra        = fh_r;
    b_re        = accept;
    b_ra        = bh_r;

    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          st_nxt     = ST_FIN;
          val_nxt    = DATA_WIDTH'($unsigned(in_word.value));
          pop_ok_nxt = 1'b0;
          mv_nxt     = 1'b0;
          mv_fwd_nxt = 1'b0;
          if (in_word.mode == MODE_POP) begin
            if (tot_r == '0 || fc_r == '0) begin
              stat_nxt = STAT_EMPTY;
            end else begin
              stat_nxt   = STAT_POPPED;
              pop_ok_nxt = 1'b1;
              fh_nxt     = fh_inc;
              fc_nxt     = fc_dec;
              tot_nxt    = tot_dec;
              // Refill the front half from the back head if it fell short.
              if (TOT_W'(fc_dec) < half_up(tot_dec) && bc_r != '0) begin
                mv_nxt      = 1'b1;
                mv_addr_nxt = pop_tail;
                bh_nxt      = bh_inc;
                bc_nxt      = bc_r - CNT_W'(1);
                fc_nxt      = fc_r;
              end
            end
          end else if (tot_r >= TOT_W'(CAPACITY)) begin
            stat_nxt = STAT_FULL;
          end else if (in_word.mode == MODE_PUSH) begin
            stat_nxt = STAT_INSERTED;
            b_we     = 1'b1;
            b_wa     = back_tail;
            b_wd     = DATA_WIDTH'($unsigned(in_word.value));
            tot_nxt  = tot_inc;
            if (TOT_W'(fc_r) < half_up(tot_inc)) begin
              // The back head moves to the front tail. With an empty back
              // half that head is the word written in this same cycle.
              mv_nxt      = 1'b1;
              mv_fwd_nxt  = (bc_r == '0);
              mv_addr_nxt = front_tail;
              bh_nxt      = bh_inc;
              fc_nxt      = fc_r + CNT_W'(1);
            end else begin
              bc_nxt = bc_r + CNT_W'(1);
            end
          end else begin
            // Insert at the middle; both mode codes other than push and pop take this path.
            stat_nxt = STAT_INSERTED;
            tot_nxt  = tot_inc;
            if (!tot_r[0]) begin
              f_we   = 1'b1;
              f_wa   = front_tail;
              f_wd   = DATA_WIDTH'($unsigned(in_word.value));
              fc_nxt = fc_r + CNT_W'(1);
            end else begin
              b_we   = 1'b1;
              b_wa   = bh_dec;
              b_wd   = DATA_WIDTH'($unsigned(in_word.value));
              bh_nxt = bh_dec;
              bc_nxt = bc_r + CNT_W'(1);
            end
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          st_nxt   = ST_IDLE;
          out_load = 1'b1;
          if (mv_r) begin
            f_we = 1'b1;
            f_wa = mv_addr_r;
            f_wd = mv_fwd_r ? val_r : b_rd;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_load || (out_valid_r && out_stall);
    out_word_nxt  = out_word_r;
    if (out_load) begin
      out_word_nxt.status       = stat_r;
      out_word_nxt.popped_value = pop_ok_r ? VAL_W'(f_rd_s) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      fh_r        <= '0;
      fc_r        <= '0;
      bh_r        <= '0;
      bc_r        <= '0;
      tot_r       <= '0;
      mv_r        <= 1'b0;
      mv_fwd_r    <= 1'b0;
      pop_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      fh_r        <= fh_nxt;
      fc_r        <= fc_nxt;
      bh_r        <= bh_nxt;
      bc_r        <= bc_nxt;
      tot_r       <= tot_nxt;
      mv_r        <= mv_nxt;
      mv_fwd_r    <= mv_fwd_nxt;
      pop_ok_r    <= pop_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r     <= stat_nxt;
    mv_addr_r  <= mv_addr_nxt;
    val_r      <= val_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The two halves always add up to the whole queue, and the front half
  // holds ceil(tot/2) entries, the larger share when the total is odd.
  `MIQ_ASSERT_NOW(a_halves_sum, 1'b1, TOT_W'(fc_r) + TOT_W'(bc_r) == tot_r)
  `MIQ_ASSERT_NOW(a_front_balanced, 1'b1, TOT_W'(fc_r) == half_up(tot_r))
  // The queue never holds more than its capacity.
  `MIQ_ASSERT_NOW(a_within_capacity, 1'b1, tot_r <= TOT_W'(CAPACITY))
  // A finished operation always leaves a word in the output register.
  `MIQ_ASSERT_NEXT(a_result_loaded, st_r == ST_FIN && out_load, out_valid_r)

endmodule
